@@ hdl/abte_pkg.sv @@
// abte_pkg: shared sizes, operation codes and walk order codes of the array binary tree engine
// no dependencies; used by the channel interfaces and by the engine core

package abte_pkg;

	// tree store size and derived index widths
	localparam int NODE_CAPACITY = 63;
	localparam int IDX_W         = $clog2(NODE_CAPACITY);
	localparam int NODE_SLOTS    = 1 << IDX_W;
	localparam int CHILD_W       = IDX_W + 2;

	// payload field widths
	localparam int OP_W    = 3;
	localparam int NIDX_W  = 6;
	localparam int VALUE_W = 32;
	localparam int ORDER_W = 2;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_STORE  = 3'd0,
		OP_CLEAR  = 3'd1,
		OP_ROOT   = 3'd2,
		OP_PARENT = 3'd3,
		OP_LEFT   = 3'd4,
		OP_RIGHT  = 3'd5,
		OP_WALK   = 3'd6
	} op_t;

	// walk order codes
	localparam logic [ORDER_W-1:0] WALK_PRE  = 2'd0;
	localparam logic [ORDER_W-1:0] WALK_IN   = 2'd1;
	localparam logic [ORDER_W-1:0] WALK_POST = 2'd2;

endpackage

@@ hdl/abte_req_if.sv @@
// abte_req_if: request channel of the tree engine (valid/ready plus operation payload)
// depends on abte_pkg for field widths

interface abte_req_if;

	logic                                  valid;
	logic                                  ready;
	logic [abte_pkg::OP_W-1:0]             operation;
	logic [abte_pkg::NIDX_W-1:0]           node_index;
	logic signed [abte_pkg::VALUE_W-1:0]   node_value;
	logic [abte_pkg::ORDER_W-1:0]          walk_order;

	modport source (output valid, output operation, output node_index, output node_value,
		output walk_order, input ready);
	modport sink (input valid, input operation, input node_index, input node_value,
		input walk_order, output ready);

endinterface

@@ hdl/abte_rsp_if.sv @@
// abte_rsp_if: result channel of the tree engine (valid/ready plus result payload)
// depends on abte_pkg for field widths

interface abte_rsp_if;

	logic                                  valid;
	logic                                  ready;
	logic signed [abte_pkg::VALUE_W-1:0]   result_value;
	logic                                  found;
	logic                                  last;

	modport source (output valid, output result_value, output found, output last,
		input ready);
	modport sink (input valid, input result_value, input found, input last,
		output ready);

endinterface

@@ hdl/abte_ram.sv @@
// abte_ram: generic single write port, single read port ram with registered read data
// no dependencies

module abte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ hdl/array_binary_tree_engine_core.sv @@
// array_binary_tree_engine_core: array-form binary tree store with lookup and walk sequencer
// depends on abte_pkg, abte_req_if, abte_rsp_if and abte_ram
//
//   channel | modport     | moves per transfer
//   --------+-------------+-----------------------------------------------------
//   req     | sink        | operation, node_index, node_value, walk_order
//   rsp     | source      | result_value, found, last (one or more per request)
//
// store, clear, empty tree and bad codes: accepted in idle, then answered from the reply state
// root: the accept step also reads slot 0; the fetch state then replies with the read data
// parent/left/right: value scan at one slot per cycle up to the last slot, then a reply,
//   which carries the target read on a hit with a live target; one ram read port sets the pace
// walk: each reachable node is visited down, back from left and back from right, then a
//   flush step closes; each emitted value is held until the next so that the final one can carry last
// reset clears all present marks at once; slot values stay undefined until written
// a full result register stalls the reply, fetch, walk and flush steps; no request is taken until the reply ends

module array_binary_tree_engine_core (
	input  logic              clk,
	input  logic              arst_n,
	abte_req_if.sink          req,
	abte_rsp_if.source        rsp
);

	localparam int IDX_W   = abte_pkg::IDX_W;
	localparam int CHILD_W = abte_pkg::CHILD_W;
	localparam int VALUE_W = abte_pkg::VALUE_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(abte_pkg::NODE_CAPACITY - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REPLY,
		ST_FETCH,
		ST_SCAN,
		ST_WALK,
		ST_FLUSH
	} state_t;

	typedef enum logic [1:0] {
		DIR_DOWN,
		DIR_FROM_LEFT,
		DIR_FROM_RIGHT
	} dir_t;

	state_t                               state_q, state_d;
	dir_t                                 dir_q, dir_d;
	abte_pkg::op_t                        op_q, op_d;
	logic [abte_pkg::ORDER_W-1:0]         order_q, order_d;
	logic [IDX_W-1:0]                     cur_q, cur_d;
	logic [VALUE_W-1:0]                   key_q, key_d;
	logic [VALUE_W-1:0]                   rv_q, rv_d;
	logic                                 rfound_q, rfound_d;
	logic [VALUE_W-1:0]                   pend_q, pend_d;
	logic                                 pend_vld_q, pend_vld_d;
	logic [abte_pkg::NODE_SLOTS-1:0]      marks_q, marks_d;
	logic                                 ovalid_q;
	logic [VALUE_W-1:0]                   oval_q;
	logic                                 ofound_q;
	logic                                 olast_q;

	logic                                 push;
	logic [VALUE_W-1:0]                   push_val;
	logic                                 push_found;
	logic                                 push_last;
	logic                                 can_push;
	logic                                 ram_we;
	logic [VALUE_W-1:0]                   rdata;
	logic [IDX_W-1:0]                     cur_dec;
	logic [CHILD_W-1:0]                   par_idx;
	logic [CHILD_W-1:0]                   left_idx;
	logic [CHILD_W-1:0]                   right_idx;
	logic [CHILD_W-1:0]                   tgt_idx;
	logic                                 tgt_ok;
	logic                                 hit;
	logic                                 emit_now;

	// slot exists in the store and carries a present mark
	function automatic logic slot_live(logic [CHILD_W-1:0] idx,
		logic [abte_pkg::NODE_SLOTS-1:0] marks);
		logic in_range;
		in_range = idx < CHILD_W'(abte_pkg::NODE_CAPACITY);
		return in_range && marks[idx[IDX_W-1:0]];
	endfunction

	// slot value store; read address follows the next node so data lines up with cur_q
	abte_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (abte_pkg::NODE_CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (IDX_W'(req.node_index)),
		.wdata (req.node_value),
		.raddr (cur_d),
		.rdata (rdata)
	);

	// neighbor indices of the current node
	assign cur_dec   = cur_q - IDX_W'(1);
	assign par_idx   = {2'b00, cur_dec >> 1};
	assign left_idx  = {1'b0, cur_q, 1'b1};
	assign right_idx = {1'b0, cur_q, 1'b0} + CHILD_W'(2);

	// scan match and lookup target
	assign hit = marks_q[cur_q] && (rdata == key_q);

	always_comb begin
		tgt_idx = right_idx;
		tgt_ok  = 1'b1;
		unique case (op_q)
			abte_pkg::OP_PARENT: begin
				tgt_idx = par_idx;
				tgt_ok  = cur_q != '0;
			end
			abte_pkg::OP_LEFT: tgt_idx = left_idx;
			default:           tgt_idx = right_idx;
		endcase
	end

	// walk emits on the visit that matches the order
	assign emit_now = (dir_q == DIR_DOWN && order_q == abte_pkg::WALK_PRE) ||
		(dir_q == DIR_FROM_LEFT && order_q == abte_pkg::WALK_IN) ||
		(dir_q == DIR_FROM_RIGHT && order_q == abte_pkg::WALK_POST);

	assign can_push  = !ovalid_q || rsp.ready;
	assign req.ready = state_q == ST_IDLE;

	// sequencer next state
	always_comb begin
		state_d    = state_q;
		dir_d      = dir_q;
		op_d       = op_q;
		order_d    = order_q;
		cur_d      = cur_q;
		key_d      = key_q;
		rv_d       = rv_q;
		rfound_d   = rfound_q;
		pend_d     = pend_q;
		pend_vld_d = pend_vld_q;
		marks_d    = marks_q;
		push       = 1'b0;
		push_val   = '0;
		push_found = 1'b0;
		push_last  = 1'b0;
		ram_we     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					op_d     = abte_pkg::op_t'(req.operation);
					order_d  = req.walk_order;
					key_d    = req.node_value;
					rv_d     = '0;
					rfound_d = 1'b0;
					cur_d    = '0;
					dir_d    = DIR_DOWN;
					state_d  = ST_REPLY;
					unique case (abte_pkg::op_t'(req.operation))
						abte_pkg::OP_STORE: begin
							if (int'(req.node_index) < abte_pkg::NODE_CAPACITY) begin
								ram_we   = 1'b1;
								marks_d[IDX_W'(req.node_index)] = 1'b1;
								rv_d     = req.node_value;
								rfound_d = 1'b1;
							end
						end
						abte_pkg::OP_CLEAR: begin
							marks_d  = '0;
							rfound_d = 1'b1;
						end
						abte_pkg::OP_ROOT: begin
							if (marks_q[0]) begin
								state_d = ST_FETCH;
							end
						end
						abte_pkg::OP_PARENT, abte_pkg::OP_LEFT, abte_pkg::OP_RIGHT: begin
							if (marks_q[0]) begin
								state_d = ST_SCAN;
							end
						end
						abte_pkg::OP_WALK: begin
							if (marks_q[0] && req.walk_order <= abte_pkg::WALK_POST) begin
								state_d = ST_WALK;
							end
						end
						default: ;
					endcase
				end
			end
			ST_REPLY: begin
				if (can_push) begin
					push       = 1'b1;
					push_val   = rv_q;
					push_found = rfound_q;
					push_last  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FETCH: begin
				if (can_push) begin
					push       = 1'b1;
					push_val   = rdata;
					push_found = 1'b1;
					push_last  = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_SCAN: begin
				// one slot per cycle, first match wins
				if (hit) begin
					if (tgt_ok && slot_live(tgt_idx, marks_q)) begin
						cur_d   = tgt_idx[IDX_W-1:0];
						state_d = ST_FETCH;
					end else begin
						state_d = ST_REPLY;
					end
				end else if (cur_q == LAST_IDX) begin
					state_d = ST_REPLY;
				end else begin
					cur_d = cur_q + IDX_W'(1);
				end
			end
			ST_WALK: begin
				// stackless walk: parent index replaces the return stack
				if (!(emit_now && pend_vld_q && !can_push)) begin
					if (emit_now) begin
						push       = pend_vld_q;
						push_val   = pend_q;
						push_found = 1'b1;
						pend_d     = rdata;
						pend_vld_d = 1'b1;
					end
					unique case (dir_q)
						DIR_DOWN: begin
							if (slot_live(left_idx, marks_q)) begin
								cur_d = left_idx[IDX_W-1:0];
							end else begin
								dir_d = DIR_FROM_LEFT;
							end
						end
						DIR_FROM_LEFT: begin
							if (slot_live(right_idx, marks_q)) begin
								cur_d = right_idx[IDX_W-1:0];
								dir_d = DIR_DOWN;
							end else begin
								dir_d = DIR_FROM_RIGHT;
							end
						end
						default: begin
							if (cur_q == '0) begin
								state_d = ST_FLUSH;
							end else begin
								cur_d = par_idx[IDX_W-1:0];
								dir_d = cur_q[0] ? DIR_FROM_LEFT : DIR_FROM_RIGHT;
							end
						end
					endcase
				end
			end
			ST_FLUSH: begin
				if (can_push) begin
					push       = 1'b1;
					push_val   = pend_q;
					push_found = 1'b1;
					push_last  = 1'b1;
					pend_vld_d = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer state, marks and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			dir_q      <= DIR_DOWN;
			op_q       <= abte_pkg::OP_STORE;
			order_q    <= '0;
			cur_q      <= '0;
			key_q      <= '0;
			rv_q       <= '0;
			rfound_q   <= 1'b0;
			pend_q     <= '0;
			pend_vld_q <= 1'b0;
			marks_q    <= '0;
			ovalid_q   <= 1'b0;
			oval_q     <= '0;
			ofound_q   <= 1'b0;
			olast_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			dir_q      <= dir_d;
			op_q       <= op_d;
			order_q    <= order_d;
			cur_q      <= cur_d;
			key_q      <= key_d;
			rv_q       <= rv_d;
			rfound_q   <= rfound_d;
			pend_q     <= pend_d;
			pend_vld_q <= pend_vld_d;
			marks_q    <= marks_d;
			if (push) begin
				ovalid_q <= 1'b1;
				oval_q   <= push_val;
				ofound_q <= push_found;
				olast_q  <= push_last;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid        = ovalid_q;
	assign rsp.result_value = oval_q;
	assign rsp.found        = ofound_q;
	assign rsp.last         = olast_q;

`ifndef SYNTHESIS
	// no walk value is left behind once the engine is idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !pend_vld_q)
		else $error("held walk value while idle");

	// the final walk step always has a value to close with
	a_flush_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> pend_vld_q)
		else $error("walk ended without a held value");

	// the sequencer only ever points at slots inside the store
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_WALK || state_q == ST_FETCH)
		|-> int'(cur_q) < abte_pkg::NODE_CAPACITY)
		else $error("node index out of range");

	// a clear transfer empties the tree
	a_clear_marks: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.operation == abte_pkg::OP_CLEAR |=> marks_q == '0)
		else $error("marks not cleared");

	// a result that was not found carries zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.found |-> rsp.result_value == '0)
		else $error("nonzero value on a miss");
`endif

endmodule
